>>> src/ppu_sprite_evaluation_defines.svh
// ----------------------------------------------------------------------------
// ppu sprite evaluation assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef PPU_SPRITE_EVALUATION_DEFINES_SVH
`define PPU_SPRITE_EVALUATION_DEFINES_SVH

// checked only outside reset
`define PPU_SE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PPU_SE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/ppu_se_pkg.sv
// ----------------------------------------------------------------------------
// ppu sprite evaluation package
// sprite record type, codes and fixed constants
// ----------------------------------------------------------------------------
package ppu_se_pkg;

	typedef struct packed {
		logic [7:0] y;
		logic [7:0] tile;
		logic [7:0] attr;
		logic [7:0] x;
	} sprite_t;

	typedef struct packed {
		logic [3:0] count;
		logic       overflow;
		logic       sprite0;
	} sel_status_t;

	typedef struct packed {
		logic    en;
		sprite_t data;
	} sec_wr_t;

	localparam int OAM_WORDS = 64;
	localparam int OAM_WAW   = 6;
	localparam int MAX_SLOTS = 8;

	localparam logic       CMD_WRITE = 1'b0;
	localparam logic       CMD_EVAL  = 1'b1;

	localparam logic       REG_SHOW = 1'b0;
	localparam logic       REG_TALL = 1'b1;

	localparam logic [1:0] LANE_Y    = 2'd0;
	localparam logic [1:0] LANE_TILE = 2'd1;
	localparam logic [1:0] LANE_ATTR = 2'd2;
	localparam logic [1:0] LANE_X    = 2'd3;

	localparam logic [7:0] EMPTY_BYTE = 8'hff;
	localparam logic [9:0] HEIGHT_SHORT = 10'd8;
	localparam logic [9:0] HEIGHT_TALL  = 10'd16;

endpackage

>>> src/ppu_se_ram.sv
// ----------------------------------------------------------------------------
// ppu sprite evaluation ram
// generic one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module ppu_se_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/ppu_se_select.sv
// ----------------------------------------------------------------------------
// ppu sprite evaluation selector
// range test on each fetched sprite, slot fill and sticky flags
// ----------------------------------------------------------------------------
module ppu_se_select #(
	parameter int SLOTS = 8,
	localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  hit_s1,
	input  logic                  first_s1,
	input  ppu_se_pkg::sprite_t   spr,
	input  logic [8:0]            line,
	input  logic                  tall,
	output ppu_se_pkg::sec_wr_t   sec_wr,
	output logic [SAW-1:0]        sec_waddr,
	output ppu_se_pkg::sel_status_t status
);

	logic [3:0] count_q;
	logic       ovf_q;
	logic       s0_q;
	logic [9:0] lo;
	logic [9:0] hi;
	logic [9:0] line_x;
	logic       in_range;
	logic       full;

	assign line_x   = {1'b0, line};
	assign lo       = {2'b00, spr.y} + 10'd1;
	assign hi       = lo + (tall ? ppu_se_pkg::HEIGHT_TALL : ppu_se_pkg::HEIGHT_SHORT);
	assign in_range = (line_x >= lo) && (line_x < hi);
	assign full     = (count_q >= 4'(SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			s0_q    <= 1'b0;
		end else if (start) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			s0_q    <= 1'b0;
		end else if (hit_s1 && in_range) begin
			if (first_s1) begin
				s0_q <= 1'b1;
			end
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + 4'd1;
			end
		end
	end

	assign sec_wr.en       = hit_s1 && in_range && !full;
	assign sec_wr.data     = spr;
	assign sec_waddr       = count_q[SAW-1:0];
	assign status.count    = count_q;
	assign status.overflow = ovf_q;
	assign status.sprite0  = s0_q;

endmodule

>>> src/ppu_sprite_evaluation.sv
// Sprite evaluation for one scanline. After reset the 64-word attribute
// memory is cleared, during which no request is taken (configuration
// writes are). A byte write reads the word and merges the byte back in
// through the single read port. An evaluation reads one sprite per cycle
// during the scan, then each picked sprite is read from the slot buffer
// into the result register; a skipped evaluation or one with no sprite in
// range gives its single result at once. The next request is taken once
// the final result sits in the output register.
// ----------------------------------------------------------------------------
// ppu sprite evaluation top level
// attribute memory, scan sequencer and result register
// ----------------------------------------------------------------------------
module ppu_sprite_evaluation #(
	parameter int SPRITE_COUNT = 64,
	parameter int LINE_SLOTS   = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] oam_index,
	input  logic [7:0] oam_value,
	input  logic [8:0] line_number,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] slot,
	output logic [7:0] sprite_y,
	output logic [7:0] sprite_tile,
	output logic [7:0] sprite_attr,
	output logic [7:0] sprite_x,
	output logic [3:0] sprite_count,
	output logic       overflow,
	output logic       sprite0_found,
	output logic       last
);

	localparam int SLOTS = (LINE_SLOTS > ppu_se_pkg::MAX_SLOTS) ?
		ppu_se_pkg::MAX_SLOTS : LINE_SLOTS;
	localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IW  = $clog2(SPRITE_COUNT);
	localparam int OW  = ppu_se_pkg::OAM_WAW;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MERGE = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;
	localparam logic [2:0] ST_LOAD  = 3'd6;

	logic [2:0]    state_q;
	logic [OW-1:0] clr_q;
	logic [OW-1:0] wr_word_q;
	logic [1:0]    wr_lane_q;
	logic [7:0]    wr_val_q;
	logic [8:0]    line_q;
	logic [IW-1:0] scan_q;
	logic [3:0]    k_q;
	logic          empty_q;
	logic          show_q;
	logic          tall_q;
	logic          hit_s1;
	logic          first_s1;

	logic          out_valid_q;
	logic [2:0]    slot_q;
	ppu_se_pkg::sprite_t spr_q;
	logic [3:0]    count_q;
	logic          ovf_q;
	logic          s0_q;
	logic          last_q;

	logic          accept;
	logic          start;
	logic          out_free;
	logic [IW+OW-1:0] scan_ext;
	logic [OW-1:0] scan_word;
	logic          oam_we;
	logic [OW-1:0] oam_waddr;
	ppu_se_pkg::sprite_t oam_wdata;
	ppu_se_pkg::sprite_t merged;
	logic [OW-1:0] oam_raddr;
	ppu_se_pkg::sprite_t oam_rdata;
	ppu_se_pkg::sec_wr_t sec_wr;
	logic [SAW-1:0] sec_waddr;
	ppu_se_pkg::sprite_t sec_rdata;
	ppu_se_pkg::sel_status_t status;
	logic          no_pick;
	logic          final_pick;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign start      = accept && (cmd == ppu_se_pkg::CMD_EVAL) && show_q &&
		(line_number != 9'd0);
	assign out_free   = !out_valid_q || out_ready;
	assign scan_ext   = {{OW{1'b0}}, scan_q};
	assign scan_word  = scan_ext[OW-1:0];
	assign no_pick    = empty_q || (status.count == 4'd0);
	assign final_pick = ((k_q + 4'd1) == status.count);

	// byte merge into the fetched word
	always_comb begin
		merged = oam_rdata;
		case (wr_lane_q)
			ppu_se_pkg::LANE_Y:    merged.y    = wr_val_q;
			ppu_se_pkg::LANE_TILE: merged.tile = wr_val_q;
			ppu_se_pkg::LANE_ATTR: merged.attr = wr_val_q;
			ppu_se_pkg::LANE_X:    merged.x    = wr_val_q;
			default:               merged      = oam_rdata;
		endcase
	end

	assign oam_we    = (state_q == ST_CLEAR) || (state_q == ST_MERGE);
	assign oam_waddr = (state_q == ST_CLEAR) ? clr_q : wr_word_q;
	assign oam_wdata = (state_q == ST_CLEAR) ? '0 : merged;
	assign oam_raddr = (state_q == ST_IDLE) ? oam_index[7:2] : scan_word;

	ppu_se_ram #(
		.WIDTH($bits(ppu_se_pkg::sprite_t)),
		.DEPTH(ppu_se_pkg::OAM_WORDS)
	) u_oam (
		.clk  (clk),
		.we   (oam_we),
		.waddr(oam_waddr),
		.wdata(oam_wdata),
		.raddr(oam_raddr),
		.rdata(oam_rdata)
	);

	ppu_se_select #(
		.SLOTS(SLOTS)
	) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.hit_s1   (hit_s1),
		.first_s1 (first_s1),
		.spr      (oam_rdata),
		.line     (line_q),
		.tall     (tall_q),
		.sec_wr   (sec_wr),
		.sec_waddr(sec_waddr),
		.status   (status)
	);

	ppu_se_ram #(
		.WIDTH($bits(ppu_se_pkg::sprite_t)),
		.DEPTH(SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (sec_wr.en),
		.waddr(sec_waddr),
		.wdata(sec_wr.data),
		.raddr(k_q[SAW-1:0]),
		.rdata(sec_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			show_q <= 1'b0;
			tall_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				ppu_se_pkg::REG_SHOW: show_q <= cfg_data;
				ppu_se_pkg::REG_TALL: tall_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			scan_q   <= '0;
			k_q      <= '0;
			empty_q  <= 1'b0;
			hit_s1   <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			hit_s1   <= (state_q == ST_SCAN);
			first_s1 <= (state_q == ST_SCAN) && (scan_q == '0);
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + OW'(1);
					if (clr_q == OW'(ppu_se_pkg::OAM_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						k_q    <= '0;
						scan_q <= '0;
						if (cmd == ppu_se_pkg::CMD_WRITE) begin
							state_q <= ST_MERGE;
						end else if (start) begin
							empty_q <= 1'b0;
							state_q <= ST_SCAN;
						end else begin
							empty_q <= 1'b1;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_MERGE: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					scan_q <= scan_q + IW'(1);
					if (scan_q == IW'(SPRITE_COUNT - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= no_pick ? ST_IDLE : ST_LOAD;
					end
				end
				ST_LOAD: begin
					k_q     <= k_q + 4'd1;
					state_q <= final_pick ? ST_IDLE : ST_EMIT;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			wr_word_q <= oam_index[7:2];
			wr_lane_q <= oam_index[1:0];
			wr_val_q  <= oam_value;
			line_q    <= line_number;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT && out_free && no_pick) ||
			state_q == ST_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free && no_pick) begin
			slot_q  <= 3'd0;
			spr_q   <= {4{ppu_se_pkg::EMPTY_BYTE}};
			count_q <= 4'd0;
			ovf_q   <= status.overflow;
			s0_q    <= status.sprite0;
			last_q  <= 1'b1;
		end else if (state_q == ST_LOAD) begin
			slot_q  <= k_q[2:0];
			spr_q   <= sec_rdata;
			count_q <= status.count;
			ovf_q   <= status.overflow;
			s0_q    <= status.sprite0;
			last_q  <= final_pick;
		end
	end

	assign out_valid     = out_valid_q;
	assign slot          = slot_q;
	assign sprite_y      = spr_q.y;
	assign sprite_tile   = spr_q.tile;
	assign sprite_attr   = spr_q.attr;
	assign sprite_x      = spr_q.x;
	assign sprite_count  = count_q;
	assign overflow      = ovf_q;
	assign sprite0_found = s0_q;
	assign last          = last_q;

endmodule

>>> src/ppu_se_checker.sv
// ----------------------------------------------------------------------------
// ppu sprite evaluation checker
// port-level properties of the result stream
// ----------------------------------------------------------------------------
`include "ppu_sprite_evaluation_defines.svh"

module ppu_se_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] slot,
	input logic [7:0] sprite_y,
	input logic [7:0] sprite_x,
	input logic [3:0] sprite_count,
	input logic       last
);

	logic empty_res;
	logic empty_ok;
	logic picked_res;
	logic last_ok;
	logic stalled;

	assign empty_res  = out_valid && (sprite_count == 4'd0);
	assign empty_ok   = last && (slot == 3'd0) && (sprite_y == 8'hff);
	assign picked_res = out_valid && (sprite_count != 4'd0);
	assign last_ok    = (last == ({1'b0, slot} == (sprite_count - 4'd1)));
	assign stalled    = out_valid && !out_ready;

	`PPU_SE_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !out_valid, "result during reset")

	`PPU_SE_ASSERT(a_empty_shape, empty_res |-> empty_ok, "malformed empty result")

	`PPU_SE_ASSERT(a_last_on_final_slot, picked_res |-> last_ok, "last does not match slot")

	`PPU_SE_ASSERT(a_hold_when_stalled, stalled |=> out_valid && $stable({slot, sprite_x}), "stalled result changed")

endmodule

bind ppu_sprite_evaluation ppu_se_checker u_ppu_se_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppu sprite evaluation testbench
// fills the attribute memory and requests scanline evaluations under random
// idle and stall bursts, predicts the selected sprites and flags, and checks
// every result in order
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic       cmd;
		logic [7:0] idx;
		logic [7:0] val;
		logic [8:0] line;
	} oam_req_t;

	typedef struct {
		logic [2:0]          slot;
		ppu_se_pkg::sprite_t spr;
		logic [3:0]          count;
		logic                ovf;
		logic                s0;
		logic                last;
	} sel_sprite_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b1;
	logic       cfg_write = 1'b0;
	logic       cfg_index = ppu_se_pkg::REG_SHOW;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       cmd = ppu_se_pkg::CMD_WRITE;
	logic [7:0] oam_index = 8'd0;
	logic [7:0] oam_value = 8'd0;
	logic [8:0] line_number = 9'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] slot;
	logic [7:0] sprite_y;
	logic [7:0] sprite_tile;
	logic [7:0] sprite_attr;
	logic [7:0] sprite_x;
	logic [3:0] sprite_count;
	logic       overflow;
	logic       sprite0_found;
	logic       last;

	oam_req_t    oam_requests[$];
	sel_sprite_t expected_sprites[$];
	oam_req_t    on_bus;
	sel_sprite_t want;
	int          requests_sent = 0;
	int          requests_taken = 0;
	int          errors = 0;
	int          idle_left = 0;
	int          stall_left = 0;
	bit          calm = 1'b0;

	logic [7:0] oam_copy [256];
	logic       ovf_flag = 1'b0;
	logic       zero_hit = 1'b0;
	logic       show_en = 1'b0;
	logic       tall_en = 1'b0;

	ppu_sprite_evaluation u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.oam_index    (oam_index),
		.oam_value    (oam_value),
		.line_number  (line_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.slot         (slot),
		.sprite_y     (sprite_y),
		.sprite_tile  (sprite_tile),
		.sprite_attr  (sprite_attr),
		.sprite_x     (sprite_x),
		.sprite_count (sprite_count),
		.overflow     (overflow),
		.sprite0_found(sprite0_found),
		.last         (last)
	);

	always #4 clk = ~clk;

	function automatic void push_empty_line();
		sel_sprite_t r;
		r.slot  = 3'd0;
		r.spr   = {ppu_se_pkg::EMPTY_BYTE, ppu_se_pkg::EMPTY_BYTE,
			ppu_se_pkg::EMPTY_BYTE, ppu_se_pkg::EMPTY_BYTE};
		r.count = 4'd0;
		r.ovf   = ovf_flag;
		r.s0    = zero_hit;
		r.last  = 1'b1;
		expected_sprites.insert(expected_sprites.size(), r);
	endfunction

	function automatic void predict_scanline(oam_req_t rq);
		ppu_se_pkg::sprite_t picked[$];
		sel_sprite_t r;
		int          y;
		int          h;
		int          ln;
		int          i;
		int          k;
		if (rq.cmd == ppu_se_pkg::CMD_WRITE) begin
			oam_copy[rq.idx] = rq.val;
			return;
		end
		ln = rq.line;
		if (!show_en || ln == 0) begin
			push_empty_line();
			return;
		end
		ovf_flag = 1'b0;
		zero_hit = 1'b0;
		h = tall_en ? 16 : 8;
		for (i = 0; i < ppu_se_pkg::OAM_WORDS; i++) begin
			y = oam_copy[4 * i];
			if (y + 1 <= ln && ln < y + 1 + h) begin
				if (i == 0)
					zero_hit = 1'b1;
				if (picked.size() >= ppu_se_pkg::MAX_SLOTS)
					ovf_flag = 1'b1;
				else
					picked.insert(picked.size(), {oam_copy[4 * i], oam_copy[4 * i + 1],
						oam_copy[4 * i + 2], oam_copy[4 * i + 3]});
			end
		end
		if (picked.size() == 0) begin
			push_empty_line();
			return;
		end
		for (k = 0; k < picked.size(); k++) begin
			r.slot  = 3'(k);
			r.spr   = picked[k];
			r.count = 4'(picked.size());
			r.ovf   = ovf_flag;
			r.s0    = zero_hit;
			r.last  = (k == picked.size() - 1);
			expected_sprites.insert(expected_sprites.size(), r);
		end
	endfunction

	function automatic void compare_field(string name, logic [31:0] expd, logic [31:0] got);
		if (got !== expd) begin
			$error("%s: expected %0h, actual %0h", name, expd, got);
			errors++;
		end
	endfunction

	function automatic void push_write(logic [7:0] idx, logic [7:0] val);
		oam_req_t rq;
		rq.cmd  = ppu_se_pkg::CMD_WRITE;
		rq.idx  = idx;
		rq.val  = val;
		rq.line = 9'($urandom);
		oam_requests.insert(oam_requests.size(), rq);
		requests_sent++;
	endfunction

	function automatic void push_eval(logic [8:0] line);
		oam_req_t rq;
		rq.cmd  = ppu_se_pkg::CMD_EVAL;
		rq.idx  = 8'($urandom);
		rq.val  = 8'($urandom);
		rq.line = line;
		oam_requests.insert(oam_requests.size(), rq);
		requests_sent++;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			idle_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_scanline(on_bus);
				requests_taken++;
			end
			if (!in_valid || in_ready) begin
				if (idle_left > 0) begin
					idle_left <= idle_left - 1;
					in_valid  <= 1'b0;
				end else if (oam_requests.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					idle_left <= $urandom_range(0, 6);
					in_valid  <= 1'b0;
				end else begin
					on_bus = oam_requests.pop_front();
					in_valid    <= 1'b1;
					cmd         <= on_bus.cmd;
					oam_index   <= on_bus.idx;
					oam_value   <= on_bus.val;
					line_number <= on_bus.line;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_sprites.size() == 0) begin
					$error("unexpected result: slot %0d count %0d", slot, sprite_count);
					errors++;
				end else begin
					want = expected_sprites.pop_front();
					compare_field("slot", 32'(want.slot), 32'(slot));
					compare_field("sprite_y", 32'(want.spr.y), 32'(sprite_y));
					compare_field("sprite_tile", 32'(want.spr.tile), 32'(sprite_tile));
					compare_field("sprite_attr", 32'(want.spr.attr), 32'(sprite_attr));
					compare_field("sprite_x", 32'(want.spr.x), 32'(sprite_x));
					compare_field("sprite_count", 32'(want.count), 32'(sprite_count));
					compare_field("overflow", 32'(want.ovf), 32'(overflow));
					compare_field("sprite0_found", 32'(want.s0), 32'(sprite0_found));
					compare_field("last", 32'(want.last), 32'(last));
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready  <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 6);
				out_ready  <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic set_mode(input logic show, input logic tall);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= ppu_se_pkg::REG_SHOW;
		cfg_data  <= show;
		@(posedge clk);
		cfg_index <= ppu_se_pkg::REG_TALL;
		cfg_data  <= tall;
		@(posedge clk);
		cfg_write <= 1'b0;
		show_en = show;
		tall_en = tall;
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (requests_taken != requests_sent || expected_sprites.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic random_phase(input int budget);
		int n;
		int base;
		int idx;
		n = 0;
		while (n < budget) begin
			case ($urandom_range(0, 9)) inside
				[0:5]: begin
					// sprites clustered around a band of lines, then lines in that band
					base = $urandom_range(0, 255);
					repeat ($urandom_range(1, 10)) begin
						idx = 4 * $urandom_range(0, 63);
						if ($urandom_range(0, 7) == 0)
							idx = 0;
						push_write(8'(idx), 8'(base + $urandom_range(0, 20)));
						push_write(8'(idx + 1), 8'($urandom));
						push_write(8'(idx + 2), 8'($urandom));
						push_write(8'(idx + 3), 8'($urandom));
						n += 4;
					end
					repeat ($urandom_range(1, 3)) begin
						push_eval(9'(base + $urandom_range(0, 24)));
						n++;
					end
				end
				[6:7]: begin
					push_write(8'($urandom), 8'($urandom));
					n++;
				end
				default: begin
					push_eval(9'($urandom_range(0, 511)));
					n++;
				end
			endcase
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		for (int a = 0; a < 256; a++)
			oam_copy[a] = 8'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// disabled rendering and line zero
		set_mode(1'b0, 1'b0);
		push_eval(9'd0);
		push_eval(9'd100);
		drain();

		set_mode(1'b1, 1'b0);
		push_eval(9'd1);
		push_write(8'd0, 8'd10);
		push_write(8'd1, 8'h5a);
		push_write(8'd2, 8'ha5);
		push_write(8'd3, 8'hff);
		push_eval(9'd11);
		push_eval(9'd0);
		push_write(8'd252, 8'hff);
		push_write(8'd255, 8'h00);
		push_eval(9'd256);
		push_eval(9'd511);
		push_eval(9'd261);
		drain();

		set_mode(1'b1, 1'b1);
		push_eval(9'd16);
		push_eval(9'd17);
		push_eval(9'd26);
		push_eval(9'd27);
		drain();

		set_mode(1'b1, 1'b0);
		random_phase(45);
		drain();
		random_phase(45);
		drain();
		set_mode(1'b1, 1'b1);
		random_phase(80);
		drain();
		set_mode(1'b0, 1'b1);
		random_phase(60);
		drain();
		set_mode(1'b1, 1'($urandom_range(0, 1)));
		random_phase(80);
		drain();
		calm = 1'b1;
		set_mode(1'b1, 1'b0);
		random_phase(80);
		drain();
		repeat (20) @(negedge clk);

		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
